@@ hdl/quadratic_fit_window_filter_macros.svh @@
// ----------------------------------------------------------------------------
// Quadratic-fit window filter assertion macros
// Concurrent assertion forms used by the filter's top module.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_FIT_WINDOW_FILTER_MACROS_SVH
`define QUADRATIC_FIT_WINDOW_FILTER_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define QFWF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while reset is released.
`define QFWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/qfwf_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadratic-fit window filter package
// Field widths, beat types, register indexes and controller states.
// ----------------------------------------------------------------------------
package qfwf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int TAP_IDX_W  = 6;
    localparam int RES_W      = 32;
    localparam int TAPS_W     = 7;
    localparam int STEP_W     = 16;
    localparam int HSQ_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = SAMPLE_W + COEF_W;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd5;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;
    localparam logic [HSQ_W-1:0]  HSQ_RESET  = 24'd839;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HSQ  = 2'd2;

    typedef struct packed {
        logic                        op;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [COEF_W-1:0]    coef_smooth;
        logic signed [COEF_W-1:0]    coef_slope;
        logic signed [COEF_W-1:0]    coef_curve;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] smoothed;
        logic signed [RES_W-1:0] slope;
        logic signed [RES_W-1:0] curvature;
        logic signed [RES_W-1:0] predicted;
    } t_out;

    typedef struct packed {
        logic signed [COEF_W-1:0] smooth;
        logic signed [COEF_W-1:0] slope;
        logic signed [COEF_W-1:0] curve;
    } t_coefs;

    typedef struct packed {
        logic shift;
        logic scan;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SAT,
        ST_MUL,
        ST_EMIT
    } t_state;

endpackage

@@ hdl/quadratic_fit_window_filter.sv @@
// ----------------------------------------------------------------------------
// Quadratic-fit window filter
// Local quadratic least-squares fit over a sliding window of samples.
// ----------------------------------------------------------------------------
// A sample beat that completes the window starts a scan of the cell chain
// past the single coefficient RAM read port, then drains the RAM read and
// product registers, saturates, forms the prediction products and loads the
// output register; no new beat is taken until that result is loaded. Load
// beats and sample beats without a result leave the controller idle. Reset clears the window, fill count,
// controller and output register, and restores the configuration defaults.
// ----------------------------------------------------------------------------
module quadratic_fit_window_filter #(
    parameter int MAX_TAPS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  qfwf_pkg::t_in                          i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output qfwf_pkg::t_out                         o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [qfwf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [qfwf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import qfwf_pkg::*;

    `include "quadratic_fit_window_filter_macros.svh"

    // Address width of the coefficient RAM and the scan counter, the width
    // that holds a tap count up to MAX_TAPS, and the accumulator width.
    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int KW    = $clog2(MAX_TAPS + 1);
    localparam int SW    = KW + 1;
    localparam int ACC_W = PROD_W + KW;
    localparam int M1_W  = RES_W + STEP_W + 1;
    localparam int M2_W  = RES_W + HSQ_W + 1;
    localparam int PS_W  = RES_W + 26;

    localparam logic [AW-1:0] LAST_CNT = AW'(MAX_TAPS - 1);
    localparam logic [AW-1:0] DRAIN_LAST = AW'(1);
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(32'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(32'sh80000000);
    localparam logic signed [PS_W-25:0] PQ_HI = (PS_W - 24)'(32'sh7FFFFFFF);
    localparam logic signed [PS_W-25:0] PQ_LO = (PS_W - 24)'(32'sh80000000);
    localparam logic signed [PS_W-1:0]  ROUND_HALF = PS_W'(64'sd8388608);

    // ------------------------------------------------------------------
    // Configuration registers. The port never holds off a write; writes
    // must arrive only while the filter is idle: the block does not enforce it.
    // ------------------------------------------------------------------
    logic [TAPS_W-1:0] r_taps;
    logic [STEP_W-1:0] r_step;
    logic [HSQ_W-1:0]  r_hsq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= TAPS_RESET;
            r_step <= STEP_RESET;
            r_hsq  <= HSQ_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TAPS: r_taps <= i_cfg_data[TAPS_W-1:0];
                CFG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                CFG_HSQ:  r_hsq  <= i_cfg_data[HSQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective window length: zero behaves as one, and anything beyond the
    // cell chain behaves as the full chain.
    logic [KW-1:0] w_keff;

    always_comb begin
        if (r_taps == '0) begin
            w_keff = KW'(1);
        end else if (32'(r_taps) > MAX_TAPS) begin
            w_keff = KW'(MAX_TAPS);
        end else begin
            w_keff = KW'(r_taps);
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 holds the newest sample. On a sample beat every
    // cell shifts; during the scan the copies walk toward the last cell,
    // which presents window positions from the oldest down to the newest.
    // ------------------------------------------------------------------
    t_cell_ctrl                 w_cell_ctrl;
    logic signed [SAMPLE_W-1:0] w_win  [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] w_scan [MAX_TAPS];

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        if (j == 0) begin : g_head
            qfwf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_cell_ctrl),
                .i_win   (i_in_data.sample),
                .i_scan  ({SAMPLE_W{1'b0}}),
                .o_win   (w_win[j]),
                .o_scan  (w_scan[j])
            );
        end else begin : g_body
            qfwf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_cell_ctrl),
                .i_win   (w_win[j-1]),
                .i_scan  (w_scan[j-1]),
                .o_win   (w_win[j]),
                .o_scan  (w_scan[j])
            );
        end
    end

    // ------------------------------------------------------------------
    // Coefficient RAM: one row of three coefficients per tap.
    // ------------------------------------------------------------------
    logic                    w_ram_we;
    logic [AW-1:0]           w_ram_raddr;
    logic [$bits(t_coefs)-1:0] w_ram_rdata;
    t_coefs                  w_ram_wdata;

    assign w_ram_wdata.smooth = i_in_data.coef_smooth;
    assign w_ram_wdata.slope  = i_in_data.coef_slope;
    assign w_ram_wdata.curve  = i_in_data.coef_curve;

    qfwf_ram #(
        .WIDTH ($bits(t_coefs)),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_in_data.tap_index)),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Controller.
    // ------------------------------------------------------------------
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] n_cnt;
    logic [KW-1:0] r_fill;
    logic [KW-1:0] n_fill;
    logic [KW-1:0] w_fill_inc;
    logic          w_accept;
    logic          w_mac_clear;
    logic          w_tap_valid;
    logic [SW-1:0] w_tap_sum;
    logic          w_out_free;
    logic          w_out_load;
    logic          r_out_valid;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fill_inc = (r_fill == KW'(MAX_TAPS)) ? r_fill : r_fill + KW'(1);

    // Scan step r_cnt shows window position MAX_TAPS-1-r_cnt at the last
    // cell. Only the K newest positions take part; the first of them pairs
    // with coefficient row 0.
    assign w_tap_sum   = SW'(r_cnt) + SW'(w_keff);
    assign w_tap_valid = (w_tap_sum >= SW'(MAX_TAPS));
    assign w_ram_raddr = AW'(w_tap_sum - SW'(MAX_TAPS));

    always_comb begin
        n_state           = r_state;
        n_cnt             = r_cnt;
        n_fill            = r_fill;
        w_cell_ctrl.shift = 1'b0;
        w_cell_ctrl.scan  = 1'b0;
        w_ram_we          = 1'b0;
        w_mac_clear       = 1'b0;
        w_out_load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.op == OP_LOAD) begin
                        w_ram_we = (32'(i_in_data.tap_index) < MAX_TAPS);
                    end else begin
                        w_cell_ctrl.shift = 1'b1;
                        n_fill            = w_fill_inc;
                        if (w_fill_inc >= w_keff) begin
                            w_mac_clear = 1'b1;
                            n_cnt       = '0;
                            n_state     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                w_cell_ctrl.scan = 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_DRAIN: begin
                // Lets the registered RAM read and the product register drain.
                if (r_cnt == DRAIN_LAST) begin
                    n_state = ST_SAT;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_SAT: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fill  <= n_fill;
        end
    end

    // ------------------------------------------------------------------
    // Tap sample aligned with the registered RAM read, then the MAC.
    // ------------------------------------------------------------------
    logic                       r_v1;
    logic signed [SAMPLE_W-1:0] r_x1;
    logic signed [ACC_W-1:0]    w_acc_smooth;
    logic signed [ACC_W-1:0]    w_acc_slope;
    logic signed [ACC_W-1:0]    w_acc_curve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_SCAN) && w_tap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= w_scan[MAX_TAPS-1];
    end

    qfwf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_mac_clear),
        .i_valid      (r_v1),
        .i_x          (r_x1),
        .i_coefs      (t_coefs'(w_ram_rdata)),
        .o_acc_smooth (w_acc_smooth),
        .o_acc_slope  (w_acc_slope),
        .o_acc_curve  (w_acc_curve)
    );

    // ------------------------------------------------------------------
    // Saturation, prediction products and the final rounded sum.
    // ------------------------------------------------------------------
    logic signed [RES_W-1:0] r_sv;
    logic signed [RES_W-1:0] r_ss;
    logic signed [RES_W-1:0] r_sc;
    logic signed [M1_W-1:0]  r_m1;
    logic signed [M2_W-1:0]  r_m2;
    logic signed [PS_W-1:0]  w_psum;
    logic signed [PS_W-25:0] w_pq;
    logic signed [RES_W-1:0] w_pred;
    t_out                    r_out;

    function automatic logic signed [RES_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
        logic signed [RES_W-1:0] res;
        if (a > ACC_HI) begin
            res = ACC_HI[RES_W-1:0];
        end else if (a < ACC_LO) begin
            res = ACC_LO[RES_W-1:0];
        end else begin
            res = a[RES_W-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SAT) begin
            r_sv <= sat_acc(w_acc_smooth);
            r_ss <= sat_acc(w_acc_slope);
            r_sc <= sat_acc(w_acc_curve);
        end
        if (r_state == ST_MUL) begin
            r_m1 <= M1_W'(r_ss * $signed({1'b0, r_step}));
            r_m2 <= M2_W'(r_sc * $signed({1'b0, r_hsq}));
        end
    end

    // value*2^24 + slope*step*2^8 + curvature*half_step_sq, rounded half up,
    // then an arithmetic shift by 24 gives the floor.
    assign w_psum = (PS_W'(r_sv) <<< 24) + (PS_W'(r_m1) <<< 8) + PS_W'(r_m2) + ROUND_HALF;
    assign w_pq   = w_psum[PS_W-1:24];

    always_comb begin
        if (w_pq > PQ_HI) begin
            w_pred = PQ_HI[RES_W-1:0];
        end else if (w_pq < PQ_LO) begin
            w_pred = PQ_LO[RES_W-1:0];
        end else begin
            w_pred = w_pq[RES_W-1:0];
        end
    end

    // Output register: a finished result waits here while the next beat
    // is already accepted on the input side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.smoothed  <= r_sv;
            r_out.slope     <= r_ss;
            r_out.curvature <= r_sc;
            r_out.predicted <= w_pred;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `QFWF_ASSERT_NEXT(a_full_window_scans, i_clk, i_rst_n,
        w_accept && (i_in_data.op == OP_SAMPLE) && (w_fill_inc >= w_keff),
        r_state == ST_SCAN, "full window sample beat did not start a scan")
    `QFWF_ASSERT_SAME(a_tap_only_in_scan, i_clk, i_rst_n,
        r_v1, (r_state == ST_SCAN) || (r_state == ST_DRAIN),
        "MAC tap valid outside the scan")
    `QFWF_ASSERT_NEXT(a_emit_loads_output, i_clk, i_rst_n,
        (r_state == ST_EMIT) && w_out_free,
        o_out_valid && (r_state == ST_IDLE), "result not delivered to output register")
    `QFWF_ASSERT_SAME(a_fill_bounded, i_clk, i_rst_n,
        r_state == ST_SCAN, r_fill >= w_keff, "scan started with a partial window")

endmodule

@@ hdl/qfwf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qfwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/qfwf_cell.sv @@
// ----------------------------------------------------------------------------
// Window cell
// Holds one window sample and one scan copy, both fed from the neighbor.
// ----------------------------------------------------------------------------
module qfwf_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qfwf_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [qfwf_pkg::SAMPLE_W-1:0] i_win,
    input  logic signed [qfwf_pkg::SAMPLE_W-1:0] i_scan,
    output logic signed [qfwf_pkg::SAMPLE_W-1:0] o_win,
    output logic signed [qfwf_pkg::SAMPLE_W-1:0] o_scan
);
    import qfwf_pkg::*;

    logic signed [SAMPLE_W-1:0] r_win;
    logic signed [SAMPLE_W-1:0] r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctrl.shift) begin
            r_win <= i_win;
        end
    end

    // The scan copy takes the new window value on a shift, then walks
    // toward the last cell one position per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_scan <= i_win;
        end else if (i_ctrl.scan) begin
            r_scan <= i_scan;
        end
    end

    assign o_win  = r_win;
    assign o_scan = r_scan;

endmodule

@@ hdl/qfwf_mac.sv @@
// ----------------------------------------------------------------------------
// Triple multiply-accumulate
// Registered products, then three running sums for the three fits.
// ----------------------------------------------------------------------------
module qfwf_mac #(
    parameter int ACC_W = 55
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clear,
    input  logic                                 i_valid,
    input  logic signed [qfwf_pkg::SAMPLE_W-1:0] i_x,
    input  qfwf_pkg::t_coefs                     i_coefs,
    output logic signed [ACC_W-1:0]              o_acc_smooth,
    output logic signed [ACC_W-1:0]              o_acc_slope,
    output logic signed [ACC_W-1:0]              o_acc_curve
);
    import qfwf_pkg::*;

    logic                     r_pvalid;
    logic signed [PROD_W-1:0] r_p_smooth;
    logic signed [PROD_W-1:0] r_p_slope;
    logic signed [PROD_W-1:0] r_p_curve;
    logic signed [ACC_W-1:0]  r_acc_smooth;
    logic signed [ACC_W-1:0]  r_acc_slope;
    logic signed [ACC_W-1:0]  r_acc_curve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_smooth <= PROD_W'(i_coefs.smooth * i_x);
        r_p_slope  <= PROD_W'(i_coefs.slope * i_x);
        r_p_curve  <= PROD_W'(i_coefs.curve * i_x);
    end

    // ACC_W leaves room for a full window of products, so the sums are exact.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc_smooth <= '0;
            r_acc_slope  <= '0;
            r_acc_curve  <= '0;
        end else if (r_pvalid) begin
            r_acc_smooth <= r_acc_smooth + ACC_W'(r_p_smooth);
            r_acc_slope  <= r_acc_slope + ACC_W'(r_p_slope);
            r_acc_curve  <= r_acc_curve + ACC_W'(r_p_curve);
        end
    end

    assign o_acc_smooth = r_acc_smooth;
    assign o_acc_slope  = r_acc_slope;
    assign o_acc_curve  = r_acc_curve;

endmodule
